@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the UTF-8 decoder RTL.
// Each macro expands to one labeled concurrent assertion with a reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define UTF8D_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("utf8d assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define UTF8D_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8d assertion failed");

// The consequent holds in the cycle after the antecedent.
`define UTF8D_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8d assertion failed");

`endif

@@ rtl/core/utf8d_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, register indexes and structs of the UTF-8 decoder.
// Depends on nothing; every other module and interface of the block imports it.
package utf8d_pkg;

   localparam int LengthBits   = 24;
   localparam int ByteBits     = 8;
   localparam int CodeBits     = 31;
   localparam int NeededBits   = 24;
   localparam int BufferBits   = 24;
   localparam int PendingBits  = 3;
   localparam int CsrIndexBits = 8;
   localparam int CsrDataBits  = 24;
   localparam int CompareBits  = (LengthBits > BufferBits) ? LengthBits : BufferBits;

   localparam logic [CsrIndexBits-1:0] CSR_COUNT_ONLY   = CsrIndexBits'(0);
   localparam logic [CsrIndexBits-1:0] CSR_BUFFER_BYTES = CsrIndexBits'(1);

   localparam logic [LengthBits-1:0] LENGTH_START = LengthBits'(4);
   localparam logic [LengthBits-1:0] LENGTH_MAX   = {LengthBits{1'b1}};
   localparam logic [BufferBits-1:0] BUFFER_RESET = {BufferBits{1'b1}};
   localparam logic [BufferBits-1:0] BUFFER_MIN   = BufferBits'(4);

   typedef struct packed {
      logic [CodeBits-1:0]   code_point;
      logic                  end_of_string;
      logic [NeededBits-1:0] needed_bytes;
   } rsp_type;

   typedef struct packed {
      logic [PendingBits-1:0] bytes_pending;
      logic                   budget_full;
   } status_type;

endpackage

@@ rtl/core/utf8d_ifs.sv @@
`timescale 1ns / 1ps
// Channel interfaces of the UTF-8 decoder: request bytes, responses and
// register writes. Depends on utf8d_pkg for the payload widths.
interface utf8d_req_if import utf8d_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ByteBits-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface utf8d_rsp_if import utf8d_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CodeBits-1:0]   code_point;
   logic                  end_of_string;
   logic [NeededBits-1:0] needed_bytes;

   modport source (output valid, output code_point, output end_of_string,
                   output needed_bytes, input ready);
   modport sink (input valid, input code_point, input end_of_string,
                 input needed_bytes, output ready);
endinterface

interface utf8d_csr_if import utf8d_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CsrIndexBits-1:0] index;
   logic [CsrDataBits-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/utf8d_input_reg.sv @@
`timescale 1ns / 1ps
// Input register of the UTF-8 decoder: holds one request byte until the
// decode step can take it. Depends on utf8d_pkg and utf8d_req_if.
module utf8d_input_reg import utf8d_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   utf8d_req_if.sink           req_chan,
   input  logic                out_room,
   output logic                in_valid,
   output logic [ByteBits-1:0] in_byte,
   output logic                advance
);

   logic                valid_ff;
   logic                valid_in;
   logic [ByteBits-1:0] byte_ff;
   logic                take;

   assign advance        = valid_ff && out_room;
   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign valid_in       = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_chan.data_byte;
      end
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

@@ rtl/core/utf8d_decode_step.sv @@
`timescale 1ns / 1ps
// Decode step of the UTF-8 decoder: string state registers and the per-byte
// update that assembles code points and counts bytes. Depends on utf8d_pkg.
module utf8d_decode_step import utf8d_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [ByteBits-1:0]   in_byte,
   input  logic                  advance,
   input  logic                  count_only,
   input  logic [BufferBits-1:0] buffer_bytes,
   output logic                  res_push,
   output rsp_type               res,
   output status_type            status
);

   logic [PendingBits-1:0] pending_ff;
   logic [PendingBits-1:0] pending_in;
   logic [CodeBits-1:0]    partial_ff;
   logic [CodeBits-1:0]    partial_in;
   logic [LengthBits-1:0]  length_ff;
   logic [LengthBits-1:0]  length_in;
   logic                   full_ff;
   logic                   full_in;

   logic [CodeBits-1:0]    shifted;
   logic [LengthBits:0]    length_sum;
   logic [LengthBits-1:0]  length_added;
   logic                   over_budget;
   logic                   done;
   logic                   emit;
   logic [CodeBits-1:0]    done_code;

   assign shifted      = {partial_ff[CodeBits-7:0], in_byte[5:0]};
   assign length_sum   = {1'b0, length_ff} + (LengthBits+1)'(4);
   assign length_added = length_sum[LengthBits] ? LENGTH_MAX : length_sum[LengthBits-1:0];
   assign over_budget  = full_ff ||
                         (CompareBits'(length_ff) >= CompareBits'(buffer_bytes));

   always_comb begin
      pending_in = pending_ff;
      partial_in = partial_ff;
      length_in  = length_ff;
      full_in    = full_ff;
      done       = 1'b0;
      emit       = 1'b0;
      done_code  = '0;
      res        = '0;

      if (in_byte == '0) begin
         // End of string: report the total and start a new string.
         emit              = 1'b1;
         res.end_of_string = 1'b1;
         if (!count_only && (buffer_bytes < BUFFER_MIN)) begin
            res.needed_bytes = '0;
         end else begin
            res.needed_bytes = NeededBits'(length_ff);
         end
         pending_in = '0;
         partial_in = '0;
         length_in  = LENGTH_START;
         full_in    = 1'b0;
      end else if (pending_ff != '0) begin
         partial_in = shifted;
         pending_in = pending_ff - PendingBits'(1);
         if (pending_ff == PendingBits'(1)) begin
            done      = 1'b1;
            done_code = shifted;
         end
      end else if (!count_only && over_budget) begin
         full_in = 1'b1;
      end else begin
         case (in_byte) inside
            8'b0???????: begin
               done      = 1'b1;
               done_code = CodeBits'(in_byte);
            end
            8'b110?????: begin
               pending_in = PendingBits'(1);
               partial_in = CodeBits'(in_byte[4:0]);
            end
            8'b1110????: begin
               pending_in = PendingBits'(2);
               partial_in = CodeBits'(in_byte[3:0]);
            end
            8'b11110???: begin
               pending_in = PendingBits'(3);
               partial_in = CodeBits'(in_byte[2:0]);
            end
            8'b111110??: begin
               pending_in = PendingBits'(4);
               partial_in = CodeBits'(in_byte[1:0]);
            end
            8'b1111110?: begin
               pending_in = PendingBits'(5);
               partial_in = CodeBits'(in_byte[0]);
            end
            default: begin
               pending_in = pending_ff;
            end
         endcase
      end

      if (done) begin
         partial_in = '0;
         length_in  = length_added;
         if (!count_only) begin
            emit           = 1'b1;
            res.code_point = done_code;
         end
      end
   end

   assign res_push = advance && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         partial_ff <= '0;
         length_ff  <= LENGTH_START;
         full_ff    <= 1'b0;
      end else if (advance) begin
         pending_ff <= pending_in;
         partial_ff <= partial_in;
         length_ff  <= length_in;
         full_ff    <= full_in;
      end
   end

   assign status.bytes_pending = pending_ff;
   assign status.budget_full   = full_ff;

endmodule

@@ rtl/core/utf8d_out_fifo.sv @@
`timescale 1ns / 1ps
// Two-entry response buffer of the UTF-8 decoder; it keeps the decode step
// running while the receiver stalls. Depends on utf8d_pkg and utf8d_rsp_if.
module utf8d_out_fifo import utf8d_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  rsp_type   push_data,
   output logic      room,
   utf8d_rsp_if.source rsp_chan
);

   rsp_type     mem_ff [2];
   logic        wr_ptr_ff;
   logic        wr_ptr_in;
   logic        rd_ptr_ff;
   logic        rd_ptr_in;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;
   logic        pop;
   rsp_type     head;

   assign pop       = (count_ff != 2'd0) && rsp_chan.ready;
   assign wr_ptr_in = wr_ptr_ff ^ push;
   assign rd_ptr_in = rd_ptr_ff ^ pop;
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   assign room      = (count_ff != 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head                   = mem_ff[rd_ptr_ff];
   assign rsp_chan.valid         = (count_ff != 2'd0);
   assign rsp_chan.code_point    = head.code_point;
   assign rsp_chan.end_of_string = head.end_of_string;
   assign rsp_chan.needed_bytes  = head.needed_bytes;

endmodule

@@ rtl/core/utf8_to_utf32_decoder_core.sv @@
`timescale 1ns / 1ps
// Top level of the UTF-8 to UTF-32 decoder with legacy six-byte sequences.
// Depends on utf8d_pkg, the channel interfaces, utf8d_input_reg,
// utf8d_decode_step, utf8d_out_fifo and assert_macros.svh.
//
// Usage: req_chan takes one UTF-8 byte per request; a zero byte ends the string.
// rsp_chan returns one response per decoded character (unless count-only mode
// is set) and one terminator response per string carrying the bytes needed.
// csr_chan writes count_only (index 0) and buffer_bytes (index 1); it is always
// ready, and writes to other indexes are ignored. Write it only while idle.
// Throughput is one byte per cycle while the response buffer has room. A byte
// in the input register is decoded and its response registered in the buffer.
// The single decode step between the input register and the response buffer
// sets this rate. When the receiver stalls, the two-entry response buffer fills
// and then req_chan.ready drops; nothing is lost. Synchronous reset empties
// both registers, clears the string state and restores the register defaults.
`include "assert_macros.svh"

module utf8_to_utf32_decoder_core import utf8d_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   utf8d_req_if.sink   req_chan,
   utf8d_rsp_if.source rsp_chan,
   utf8d_csr_if.sink   csr_chan
);

   logic                  count_only_ff;
   logic [BufferBits-1:0] buffer_bytes_ff;
   logic                  csr_write;

   logic                  in_valid;
   logic [ByteBits-1:0]   in_byte;
   logic                  advance;
   logic                  out_room;
   logic                  res_push;
   rsp_type               res;
   status_type            status;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_only_ff   <= 1'b0;
         buffer_bytes_ff <= BUFFER_RESET;
      end else if (csr_write) begin
         case (csr_chan.index)
            CSR_COUNT_ONLY:   count_only_ff   <= csr_chan.data[0];
            CSR_BUFFER_BYTES: buffer_bytes_ff <= BufferBits'(csr_chan.data);
            default:          count_only_ff   <= count_only_ff;
         endcase
      end
   end

   utf8d_input_reg u_input_reg (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .out_room (out_room),
      .in_valid (in_valid),
      .in_byte  (in_byte),
      .advance  (advance)
   );

   utf8d_decode_step u_decode_step (
      .clock        (clock),
      .reset        (reset),
      .in_byte      (in_byte),
      .advance      (advance),
      .count_only   (count_only_ff),
      .buffer_bytes (buffer_bytes_ff),
      .res_push     (res_push),
      .res          (res),
      .status       (status)
   );

   utf8d_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res),
      .room      (out_room),
      .rsp_chan  (rsp_chan)
   );

   `UTF8D_ASSERT_ALWAYS(a_pending_range, clock, reset, status.bytes_pending <= PendingBits'(5))
   `UTF8D_ASSERT_IMPLY(a_push_needs_room, clock, reset, res_push, advance && in_valid && out_room)
   `UTF8D_ASSERT_NEXT(a_string_cleared, clock, reset, advance && (in_byte == '0), (status.bytes_pending == '0) && !status.budget_full)
   `UTF8D_ASSERT_NEXT(a_held_when_blocked, clock, reset, in_valid && !out_room, in_valid && $stable(in_byte))

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Testbench of the UTF-8 to UTF-32 decoder core: directed and random byte strings
// checked against a behavioral decoder. Depends on utf8d_pkg, utf8d_ifs and the core.
module tb;
   import utf8d_pkg::*;

   typedef logic [ByteBits-1:0] byte_list_type[$];

   localparam logic [ByteBits-1:0]     END_BYTE     = 8'h00;
   localparam logic [CsrIndexBits-1:0] CSR_UNMAPPED = CsrIndexBits'(8'hA5);
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int SETTLE_CYCLES   = 4;
   localparam int PHASE_BYTES     = 165;

   logic clock;
   logic reset;

   utf8d_req_if req_if();
   utf8d_rsp_if rsp_if();
   utf8d_csr_if csr_if();

   utf8_to_utf32_decoder_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   rsp_type predicted_chars[$];
   logic                   cfg_count_only;
   logic [BufferBits-1:0]  cfg_buffer;
   logic [PendingBits-1:0] m_pending;
   logic [CodeBits-1:0]    m_partial;
   logic [LengthBits-1:0]  m_length;
   logic                   m_full;

   int mismatches  = 0;
   int bytes_sent  = 0;
   int burst_left  = 0;
   int hold_cycles = 0;
   int stall_mode  = 0;
   int rx_cycle    = 0;
   int idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void decode_byte(input logic [ByteBits-1:0] b);
      rsp_type             r;
      logic                done;
      logic [CodeBits-1:0] code;
      r    = '0;
      done = 1'b0;
      code = '0;
      if (b == END_BYTE) begin
         r.end_of_string = 1'b1;
         r.needed_bytes  = (!cfg_count_only && cfg_buffer < BUFFER_MIN) ? '0 : m_length;
         predicted_chars.push_back(r);
         m_pending = '0;
         m_partial = '0;
         m_length  = LENGTH_START;
         m_full    = 1'b0;
         return;
      end
      if (m_pending != 0) begin
         m_partial = {m_partial[CodeBits-7:0], b[5:0]};
         m_pending--;
         if (m_pending == 0) begin
            done = 1'b1;
            code = m_partial;
         end
      end else begin
         if (!cfg_count_only && (m_full || m_length >= cfg_buffer)) begin
            m_full = 1'b1;
            return;
         end
         casez (b)
            8'b0???????: begin
               done = 1'b1;
               code = CodeBits'(b);
            end
            8'b110?????: begin
               m_pending = 3'd1;
               m_partial = CodeBits'(b[4:0]);
            end
            8'b1110????: begin
               m_pending = 3'd2;
               m_partial = CodeBits'(b[3:0]);
            end
            8'b11110???: begin
               m_pending = 3'd3;
               m_partial = CodeBits'(b[2:0]);
            end
            8'b111110??: begin
               m_pending = 3'd4;
               m_partial = CodeBits'(b[1:0]);
            end
            8'b1111110?: begin
               m_pending = 3'd5;
               m_partial = CodeBits'(b[0]);
            end
            default: begin
            end
         endcase
      end
      if (!done) return;
      m_partial = '0;
      m_length  = (m_length > LENGTH_MAX - LengthBits'(4)) ? LENGTH_MAX
                                                           : m_length + LengthBits'(4);
      if (cfg_count_only) return;
      r.code_point = code;
      predicted_chars.push_back(r);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_count_only = 1'b0;
         cfg_buffer     = BUFFER_RESET;
         m_pending      = '0;
         m_partial      = '0;
         m_length       = LENGTH_START;
         m_full         = 1'b0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_COUNT_ONLY:   cfg_count_only = csr_if.data[0];
               CSR_BUFFER_BYTES: cfg_buffer = csr_if.data[BufferBits-1:0];
               default: begin
               end
            endcase
         end
         if (req_if.valid && req_if.ready) decode_byte(req_if.data_byte);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (predicted_chars.size() == 0) begin
            $error("unexpected request result: code_point %0h end_of_string %0b",
                   rsp_if.code_point, rsp_if.end_of_string);
            mismatches++;
         end else begin
            want = predicted_chars.pop_front();
            if (rsp_if.code_point !== want.code_point) begin
               $error("code_point expected %0h actual %0h", want.code_point,
                      rsp_if.code_point);
               mismatches++;
            end
            if (rsp_if.end_of_string !== want.end_of_string) begin
               $error("end_of_string expected %0b actual %0b", want.end_of_string,
                      rsp_if.end_of_string);
               mismatches++;
            end
            if (rsp_if.needed_bytes !== want.needed_bytes) begin
               $error("needed_bytes expected %0d actual %0d", want.needed_bytes,
                      rsp_if.needed_bytes);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_if.ready <= 1'b0;
         hold_cycles--;
      end else begin
         if ($urandom_range(0, 47) == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_if.ready <= ($urandom_range(0, 1) == 1);
            default: rsp_if.ready <= ((rx_cycle % 7) < 4);
         endcase
      end
      rx_cycle++;
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_byte(input logic [ByteBits-1:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
   endtask

   task automatic send_bytes(input byte_list_type bytes);
      foreach (bytes[i]) send_byte(bytes[i]);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (predicted_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIndexBits-1:0] index,
                            input logic [CsrDataBits-1:0] data);
      wait_idle();
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   function automatic logic [ByteBits-1:0] lead_byte(input int n);
      logic [ByteBits-1:0] r;
      r = ByteBits'($urandom);
      return ~(8'hFF >> n) | (r & (8'hFF >> (n + 1)));
   endfunction

   function automatic logic [ByteBits-1:0] tail_byte();
      if ($urandom_range(0, 7) == 0) return ByteBits'($urandom_range(1, 255));
      return {2'b10, 6'($urandom)};
   endfunction

   task automatic send_string();
      int nchars;
      int n;
      int k;
      nchars = $urandom_range(0, 12);
      for (int c = 0; c < nchars; c++) begin
         k = $urandom_range(0, 19);
         if (k == 0) begin
            k = $urandom_range(0, 65);
            send_byte((k < 64) ? ByteBits'(8'h80 + k) : ((k == 64) ? 8'hFE : 8'hFF));
         end else if (k == 1) begin
            n = $urandom_range(2, 6);
            send_byte(lead_byte(n));
            repeat ($urandom_range(0, n - 2)) send_byte(tail_byte());
            break;
         end else begin
            n = (k < 11) ? 1 : $urandom_range(2, 6);
            if (n == 1) begin
               send_byte(ByteBits'($urandom_range(1, 127)));
            end else begin
               send_byte(lead_byte(n));
               repeat (n - 1) send_byte(tail_byte());
            end
         end
      end
      send_byte(END_BYTE);
   endtask

   task automatic test_single_bytes();
      send_bytes('{8'h01, 8'h7F, 8'h00});
   endtask

   task automatic test_sequence_lengths();
      send_bytes('{8'hC2, 8'h80, 8'hDF, 8'h7F, 8'hEF, 8'hBF, 8'hFF,
                   8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
                   8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h00});
   endtask

   task automatic test_invalid_leads();
      send_bytes('{8'h80, 8'hBF, 8'hFE, 8'hFF, 8'h00});
   endtask

   task automatic test_cut_sequence();
      send_bytes('{8'hE2, 8'h82, 8'h00});
   endtask

   task automatic test_budget();
      write_csr(CSR_BUFFER_BYTES, 24'd9);
      send_bytes('{8'h41, 8'hC3, 8'hA9, 8'h42, 8'h00});
      write_csr(CSR_BUFFER_BYTES, BUFFER_MIN);
      send_bytes('{8'h41, 8'h00});
      write_csr(CSR_BUFFER_BYTES, 24'd3);
      send_bytes('{8'h41, 8'h00});
   endtask

   task automatic test_count_only();
      write_csr(CSR_COUNT_ONLY, 24'd1);
      write_csr(CSR_BUFFER_BYTES, 24'd0);
      send_bytes('{8'h41, 8'hC3, 8'hA9, 8'h00});
   endtask

   task automatic test_mode_change();
      write_csr(CSR_COUNT_ONLY, 24'd0);
      write_csr(CSR_BUFFER_BYTES, 24'd8);
      send_bytes('{8'h41, 8'h42});
      write_csr(CSR_COUNT_ONLY, 24'd1);
      send_bytes('{8'h43, 8'h00});
      write_csr(CSR_COUNT_ONLY, 24'd0);
      write_csr(CSR_BUFFER_BYTES, BUFFER_RESET);
   endtask

   task automatic test_unmapped_index();
      write_csr(CSR_UNMAPPED, CsrDataBits'($urandom));
      send_bytes('{8'h41, 8'h00});
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_cycles = 100;
      repeat (40) send_byte(ByteBits'($urandom_range(1, 127)));
      send_byte(END_BYTE);
      wait_idle();
   endtask

   task automatic test_random_strings();
      int start;
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin
               write_csr(CSR_COUNT_ONLY, 24'd0);
               write_csr(CSR_BUFFER_BYTES, BUFFER_RESET);
            end
            1, 6: begin
               write_csr(CSR_COUNT_ONLY, 24'd0);
               write_csr(CSR_BUFFER_BYTES, CsrDataBits'($urandom_range(4, 60)));
            end
            2: write_csr(CSR_BUFFER_BYTES, CsrDataBits'($urandom_range(0, 3)));
            3: begin
               write_csr(CSR_COUNT_ONLY, 24'd1);
               write_csr(CSR_BUFFER_BYTES, CsrDataBits'($urandom));
            end
            4: begin
               write_csr(CSR_COUNT_ONLY, 24'd0);
               write_csr(CSR_BUFFER_BYTES, CsrDataBits'($urandom));
            end
            5: begin
               write_csr(CSR_COUNT_ONLY, 24'd1);
               write_csr(CSR_BUFFER_BYTES, 24'd0);
            end
            default: begin
               write_csr(CSR_COUNT_ONLY, 24'd0);
               write_csr(CSR_BUFFER_BYTES, BUFFER_RESET);
            end
         endcase
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES) send_string();
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = '0;
      csr_if.data      = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_single_bytes();
      test_sequence_lengths();
      test_invalid_leads();
      test_cut_sequence();
      test_budget();
      test_count_only();
      test_mode_change();
      test_unmapped_index();
      test_backpressure();
      test_random_strings();

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
